@@ src/next_smooth_size_search_top_macros.svh @@
// Assertion shorthands for the checker file.
`ifndef NEXT_SMOOTH_SIZE_SEARCH_TOP_MACROS_SVH
`define NEXT_SMOOTH_SIZE_SEARCH_TOP_MACROS_SVH

// Property that holds at every edge outside reset.
`define NSSS_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Antecedent this cycle, consequent on the next edge.
`define NSSS_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/nsss_pkg.sv @@
package nsss_pkg;

    localparam int SIZE_WIDTH = 24;
    localparam int OUT_W      = SIZE_WIDTH + 2;
    // search values stay below five times the target, target < 2^(SIZE_WIDTH+1)
    localparam int VAL_W      = SIZE_WIDTH + 4;
    localparam int RES_W      = VAL_W + 1;
    localparam int IDX_W      = $clog2(VAL_W);

    typedef enum logic [1:0] {
        MODE_ANY    = 2'd0,
        MODE_EVEN   = 2'd1,
        MODE_ODD_DN = 2'd2,
        MODE_ODD_UP = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_TEST,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic shift;
        logic test;
        logic step3;
        logic step5;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic special;
        logic p3_ge_t;
        logic p5_ge_t;
    } dp_stat_t;

    // index of the highest set bit, zero for zero
    function automatic logic [IDX_W-1:0] msb_idx(input logic [VAL_W-1:0] v);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < VAL_W; i++) begin
            if (v[i]) begin
                idx = IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

@@ src/nsss_ctrl.sv @@
module nsss_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  nsss_pkg::dp_stat_t stat,
    output nsss_pkg::dp_cmd_t  cmd
);
    import nsss_pkg::*;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = stat.special ? ST_DONE : ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                cmd.shift  = 1'b1;
                state_next = ST_TEST;
            end
            ST_TEST: begin
                cmd.test = 1'b1;
                priority if (!stat.p3_ge_t) begin
                    cmd.step3  = 1'b1;
                    state_next = ST_SHIFT;
                end else if (!stat.p5_ge_t) begin
                    cmd.step5  = 1'b1;
                    state_next = ST_SHIFT;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

@@ src/nsss_dp.sv @@
module nsss_dp (
    input  logic                            aclk,
    input  logic [nsss_pkg::SIZE_WIDTH-1:0] size_in,
    input  nsss_pkg::mode_t                 func,
    input  nsss_pkg::dp_cmd_t               cmd,
    output nsss_pkg::dp_stat_t              stat,
    output logic [nsss_pkg::OUT_W-1:0]      size_out,
    output logic                            overflow
);
    import nsss_pkg::*;

    logic [VAL_W-1:0] t_reg, p5_reg, p3_reg, best_reg;
    logic [IDX_W-1:0] shamt_reg;
    mode_t            mode_reg;
    logic             two_reg;
    logic [OUT_W-1:0] size_out_reg;
    logic             overflow_reg;

    logic [VAL_W-1:0] n_ext, t_load, v_al, v_cand, p5_x5;
    logic             special;
    logic [IDX_W-1:0] shamt_next;
    logic [RES_W-1:0] res;
    logic             res_ovf;

    // request setup
    always_comb begin
        n_ext   = VAL_W'(size_in);
        special = (size_in == '0) ||
                  ((func == MODE_EVEN) && (size_in <= SIZE_WIDTH'(2)));
        unique case (func)
            MODE_ANY:    t_load = n_ext;
            MODE_EVEN:   t_load = (n_ext + VAL_W'(size_in[0])) >> 1;
            MODE_ODD_DN: t_load = (n_ext << 1) - VAL_W'(1);
            MODE_ODD_UP: t_load = (n_ext << 1) + VAL_W'(1);
            default:     t_load = n_ext;
        endcase
    end

    // align msb of candidate to msb of target (doubling search)
    assign shamt_next = (two_reg && (p3_reg < t_reg)) ?
                        (msb_idx(t_reg) - msb_idx(p3_reg)) : '0;

    always_comb begin
        v_al   = p3_reg << shamt_reg;
        v_cand = (two_reg && (v_al < t_reg)) ? (v_al << 1) : v_al;
        p5_x5  = (p5_reg << 2) + p5_reg;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            t_reg    <= t_load;
            p5_reg   <= VAL_W'(1);
            p3_reg   <= VAL_W'(1);
            two_reg  <= (func == MODE_ANY) || (func == MODE_EVEN);
            mode_reg <= special ? MODE_ANY : func;
            best_reg <= special ? ((func == MODE_EVEN) ? VAL_W'(2) : VAL_W'(1)) : '1;
        end
        if (cmd.shift) begin
            shamt_reg <= shamt_next;
        end
        if (cmd.test && (v_cand >= t_reg) && (v_cand < best_reg)) begin
            best_reg <= v_cand;
        end
        if (cmd.step3) begin
            p3_reg <= (p3_reg << 1) + p3_reg;
        end
        if (cmd.step5) begin
            p5_reg <= p5_x5;
            p3_reg <= p5_x5;
        end
        if (cmd.out_load) begin
            size_out_reg <= res_ovf ? '1 : res[OUT_W-1:0];
            overflow_reg <= res_ovf;
        end
    end

    // final mapping back to the requested size
    always_comb begin
        unique case (mode_reg)
            MODE_ANY:    res = RES_W'(best_reg);
            MODE_EVEN:   res = {best_reg, 1'b0};
            MODE_ODD_DN: res = (RES_W'(best_reg) + RES_W'(1)) >> 1;
            MODE_ODD_UP: res = (RES_W'(best_reg) - RES_W'(1)) >> 1;
            default:     res = RES_W'(best_reg);
        endcase
        res_ovf = |res[RES_W-1:OUT_W];
    end

    assign stat.special = special;
    assign stat.p3_ge_t = (p3_reg >= t_reg);
    assign stat.p5_ge_t = (p5_reg >= t_reg);
    assign size_out     = size_out_reg;
    assign overflow     = overflow_reg;

endmodule

@@ src/next_smooth_size_search_top.sv @@
// Next 5-smooth size search.
// Input channel (s_valid/s_ready): one word carries a requested size s_size_in and a
// mode s_func (0 any, 1 even, 2 odd via 2n-1, 3 odd via 2n+1).
// Result channel (m_valid/m_ready): one word per request, m_size_out is the smallest
// qualifying size, m_overflow flags a saturated answer.
// One request is in flight at a time; s_ready is high only while the engine is idle.
// Each of the K 3^b*5^c candidates walked costs one shift-align step and one
// compare step. K grows with log3/log5 of the target, about 110 at the top of
// the 24-bit range. Zero size, and small sizes in even mode, skip the walk.
// The result sits in an output register: while the receiver stalls, the word holds
// steady and the block can still take the next request and search; it waits
// in its done state only if the previous result is still untaken.
// Reset (aresetn low, synchronous) returns the controller to idle and drops m_valid.
module next_smooth_size_search_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [nsss_pkg::SIZE_WIDTH-1:0] s_size_in,
    input  logic [1:0]                      s_func,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [nsss_pkg::OUT_W-1:0]      m_size_out,
    output logic                            m_overflow
);
    import nsss_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    mode_t    func_mode;

    assign func_mode = mode_t'(s_func);

    // sequencer: walks the candidate grid and owns both handshakes
    nsss_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // datapath: target, power registers, best so far, output word
    nsss_dp u_dp (
        .aclk     (aclk),
        .size_in  (s_size_in),
        .func     (func_mode),
        .cmd      (cmd),
        .stat     (stat),
        .size_out (m_size_out),
        .overflow (m_overflow)
    );

endmodule

@@ src/nsss_checker.sv @@
`include "next_smooth_size_search_top_macros.svh"

module nsss_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic [nsss_pkg::SIZE_WIDTH-1:0] s_size_in,
    input logic [1:0]                      s_func,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [nsss_pkg::OUT_W-1:0]      m_size_out,
    input logic                            m_overflow
);

    // stalled result word holds
    `NSSS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_size_out) && $stable(m_overflow), "result word changed while stalled")

    // one request at a time
    `NSSS_ASSERT_NEXT(a_one_inflight, aclk, aresetn, s_valid && s_ready, !s_ready, "engine took a second request")

    // sizes are never zero
    `NSSS_ASSERT(a_size_nonzero, aclk, aresetn, !m_valid || (m_size_out != '0), "zero size returned")

    // saturation gives all ones
    `NSSS_ASSERT(a_ovf_sat, aclk, aresetn, !(m_valid && m_overflow) || (&m_size_out), "overflow without saturation")

endmodule

bind next_smooth_size_search_top nsss_checker u_chk (.*);

@@ tb/tb.sv @@
module tb;
    import nsss_pkg::*;

    // Receiver hold-off long enough to fill the output register and the engine
    // behind it, so s_ready has to drop.
    localparam int HOLD_OFF_CYCLES = 600;
    // Drain allowance after the last expected word: one worst-case search.
    localparam int SETTLE_CYCLES   = 300;
    localparam int PHASE_ITEMS     = 300;
    localparam logic [SIZE_WIDTH-1:0] SIZE_MAX = '1;

    typedef struct packed {
        logic [OUT_W-1:0] size_out;
        logic             overflow;
    } smooth_answer_t;

    // Scoreboard: predicts the answer for every accepted request and checks
    // result words in order against it.
    class smooth_size_board;
        smooth_answer_t pending_answers[$];
        int unsigned    mismatches;

        function new();
            mismatches = 0;
        endfunction

        // Smallest 2^a*3^b*5^c >= t; with_two clear pins a to 0.
        function longint unsigned least_smooth(longint unsigned t, bit with_two);
            longint unsigned best, p5, p3, v;
            best = '1;
            p5 = 1;
            while (1'b1) begin
                p3 = p5;
                while (1'b1) begin
                    v = p3;
                    if (with_two) begin
                        while (v < t) v = v * 2;
                    end
                    if (v >= t && v < best) best = v;
                    if (p3 >= t) break;
                    p3 = p3 * 3;
                end
                if (p5 >= t) break;
                p5 = p5 * 5;
            end
            return best;
        endfunction

        function smooth_answer_t next_smooth_size(logic [SIZE_WIDTH-1:0] sz, mode_t fn);
            longint unsigned n, r, top;
            smooth_answer_t  ans;
            n   = longint'(sz);
            top = (64'd1 << OUT_W) - 1;
            case (fn)
                MODE_ANY: begin
                    r = (n == 0) ? 1 : least_smooth(n, 1'b1);
                end
                MODE_EVEN: begin
                    if (n <= 2) begin
                        r = 2;
                    end else begin
                        if (n[0]) n = n + 1;
                        r = 2 * least_smooth(n / 2, 1'b1);
                    end
                end
                MODE_ODD_DN: begin
                    r = (n == 0) ? 1 : (least_smooth(2 * n - 1, 1'b0) + 1) / 2;
                end
                default: begin
                    r = (n == 0) ? 1 : (least_smooth(2 * n + 1, 1'b0) - 1) / 2;
                end
            endcase
            if (r > top) begin
                ans.size_out = '1;
                ans.overflow = 1'b1;
            end else begin
                ans.size_out = OUT_W'(r);
                ans.overflow = 1'b0;
            end
            return ans;
        endfunction

        function void note_request(logic [SIZE_WIDTH-1:0] sz, mode_t fn);
            pending_answers.push_back(next_smooth_size(sz, fn));
        endfunction

        function void check_answer(logic [OUT_W-1:0] sz, logic ovf);
            smooth_answer_t exp_ans;
            if (pending_answers.size() == 0) begin
                $error("result word with no request pending: size_out %0d overflow %0d",
                       sz, ovf);
                mismatches++;
                return;
            end
            exp_ans = pending_answers.pop_front();
            if (sz !== exp_ans.size_out) begin
                $error("size_out mismatch: expected %0d, actual %0d", exp_ans.size_out, sz);
                mismatches++;
            end
            if (ovf !== exp_ans.overflow) begin
                $error("overflow mismatch: expected %0d, actual %0d", exp_ans.overflow, ovf);
                mismatches++;
            end
        endfunction
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    logic [SIZE_WIDTH-1:0] s_size_in = '0;
    logic [1:0]            s_func    = MODE_ANY;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    logic [OUT_W-1:0]      m_size_out;
    logic                  m_overflow;

    smooth_size_board board = new();

    // Idle rates in percent; the main sequence moves them between phases.
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    // Set by the main sequence, taken and cleared by the result sink.
    bit  stall_req     = 1'b0;
    // Tracks whether the sender currently has s_valid raised (blocking copy,
    // so a lowering never collides with another assignment in the same step).
    bit  offering      = 1'b0;

    next_smooth_size_search_top u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_size_in  (s_size_in),
        .s_func     (s_func),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_size_out (m_size_out),
        .m_overflow (m_overflow)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Safety net: a run that has not finished by then fails.
    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

    // Offer one request word and hold it until taken. Optionally idle
    // afterwards; without idling the next call reuses the raised valid.
    task automatic send_word(input logic [SIZE_WIDTH-1:0] sz, input mode_t fn);
        s_valid   <= 1'b1;
        s_size_in <= sz;
        s_func    <= fn;
        offering   = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_request(sz, fn);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            offering = 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < send_idle_pct);
        end
    endtask

    // Drop valid and wait out every outstanding result word.
    task automatic drain_results();
        if (offering) begin
            s_valid <= 1'b0;
            offering = 1'b0;
        end
        while (board.pending_answers.size() != 0) @(posedge aclk);
    endtask

    // Size mix: mostly random bit lengths, some tiny sizes, some near full range.
    function automatic logic [SIZE_WIDTH-1:0] random_size();
        int unsigned           pick, w;
        logic [SIZE_WIDTH-1:0] v;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            v = SIZE_WIDTH'($urandom_range(0, 16));
        end else if (pick < 15) begin
            v = SIZE_MAX - SIZE_WIDTH'($urandom_range(0, 64));
        end else begin
            w = $urandom_range(1, SIZE_WIDTH);
            v = SIZE_WIDTH'($urandom) & ((SIZE_WIDTH'(1) << w) - 1'b1);
        end
        return v;
    endfunction

    task automatic random_phase(input int count);
        for (int i = 0; i < count; i++) begin
            send_word(random_size(), mode_t'($urandom_range(0, 3)));
        end
    endtask

    // Result sink: checks every taken word, then picks m_ready for the next
    // edge. A pending stall request turns into a counted hold-off.
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                board.check_answer(m_size_out, m_overflow);
            end
            if (stall_req) begin
                stall_left = HOLD_OFF_CYCLES;
                stall_req  = 1'b0;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    initial begin : main_seq
        logic [SIZE_WIDTH-1:0] corner_sizes [5];
        corner_sizes = '{24'd0, 24'd1, 24'd2, 24'd3, SIZE_MAX};

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: zero, one, the even-mode floor and full scale in every
        // mode, then requests landing exactly on smooth values and two near 2^23.
        for (int m = 0; m < 4; m++) begin
            foreach (corner_sizes[k]) send_word(corner_sizes[k], mode_t'(m));
        end
        send_word(24'd14348907, MODE_ANY);     // 3^15 itself
        send_word(24'd4882813,  MODE_ODD_DN);  // 2n-1 = 5^10
        send_word(24'd7174453,  MODE_ODD_UP);  // 2n+1 = 3^15
        send_word(24'd8388609,  MODE_EVEN);    // odd, just above 2^23
        send_word(24'd8388608,  MODE_ODD_DN);

        // Backpressure: receiver holds off while the sender keeps offering,
        // so the output register and the engine both fill and s_ready drops.
        stall_req = 1'b1;
        for (int i = 0; i < 8; i++) begin
            send_word(random_size(), mode_t'($urandom_range(0, 3)));
        end
        drain_results();
        @(posedge aclk);

        send_idle_pct = 36;
        recv_idle_pct = 73;
        random_phase(PHASE_ITEMS);
        drain_results();
        @(posedge aclk);

        send_idle_pct = 73;
        recv_idle_pct = 36;
        random_phase(PHASE_ITEMS);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(PHASE_ITEMS);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (board.mismatches == 0 && board.pending_answers.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
